[sv/wps_pkg.sv]
// Shared types and constants for the WAV PCM stream parser.
// Holds the token passed from the header front end to the sample back end.
// No dependencies.
package wps_pkg;

    // Chunk tags as they sit in the shift register after four bytes (little-endian)
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] TAG_JUNK = 32'h4B4E_554A;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [3:0] ERR_RIFF     = 4'd1;
    localparam logic [3:0] ERR_WAVE     = 4'd2;
    localparam logic [3:0] ERR_FMT      = 4'd3;
    localparam logic [3:0] ERR_COMPRESS = 4'd4;
    localparam logic [3:0] ERR_CHANNELS = 4'd5;
    localparam logic [3:0] ERR_RATE     = 4'd6;
    localparam logic [3:0] ERR_BITS     = 4'd7;
    localparam logic [3:0] ERR_DATA_TAG = 4'd8;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        TK_BYTE = 2'd0,
        TK_SIZE = 2'd1,
        TK_FMT  = 2'd2,
        TK_ERR  = 2'd3
    } t_tok_kind;

    // data: sample byte, data size, sample rate or error code by kind
    typedef struct packed {
        t_tok_kind   kind;
        logic [31:0] data;
        logic [15:0] chans;
        logic [5:0]  bits;
    } t_token;

endpackage

[sv/wps_front.sv]
// Header front end: walks the RIFF/WAVE/fmt/JUNK/data headers byte by byte
// and pushes tokens (format, error, data size, sample bytes). Uses wps_pkg.
module wps_front #(
    parameter int JUNK_SKIP_BYTES = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte,
    input  logic            i_file_start,
    output logic            o_push,
    output wps_pkg::t_token o_token
);
    import wps_pkg::*;

    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_JUNK    = 6'b000010,
        PH_DATATAG = 6'b000100,
        PH_SIZE    = 6'b001000,
        PH_SAMPLES = 6'b010000,
        PH_IDLE    = 6'b100000
    } t_phase;

    localparam logic [7:0] JUNK_LEN = 8'(JUNK_SKIP_BYTES);

    t_phase      r_phase, n_phase, ph;
    logic [5:0]  r_off, n_off, off;
    logic [31:0] r_acc, n_acc, acc, va;
    logic [15:0] r_chans, n_chans;
    logic [30:0] r_rate, n_rate;
    logic [5:0]  r_bits, n_bits;
    logic [7:0]  r_jcnt, n_jcnt;
    t_token      tok;
    logic        push;

    always_comb begin
        ph      = i_file_start ? PH_HEADER : r_phase;
        off     = i_file_start ? 6'd0 : r_off;
        acc     = i_file_start ? 32'd0 : r_acc;
        va      = {i_byte, acc[31:8]};
        n_phase = r_phase;
        n_off   = r_off;
        n_acc   = r_acc;
        n_chans = r_chans;
        n_rate  = r_rate;
        n_bits  = r_bits;
        n_jcnt  = r_jcnt;
        push    = 1'b0;
        tok     = '0;
        if (i_accept) begin
            n_phase = ph;
            n_off   = off;
            n_acc   = acc;
            case (ph)
                PH_IDLE: begin
                end
                PH_SAMPLES: begin
                    push      = 1'b1;
                    tok.kind  = TK_BYTE;
                    tok.data  = {24'd0, i_byte};
                end
                PH_JUNK: begin
                    n_jcnt = r_jcnt - 8'd1;
                    if (r_jcnt == 8'd1) begin
                        n_phase = PH_DATATAG;
                        n_off   = 6'd0;
                    end
                end
                PH_DATATAG: begin
                    n_acc = va;
                    n_off = off + 6'd1;
                    if (off == 6'd3) begin
                        if (va != TAG_DATA) begin
                            push     = 1'b1;
                            tok.kind = TK_ERR;
                            tok.data = {28'd0, ERR_DATA_TAG};
                            n_phase  = PH_IDLE;
                        end else begin
                            n_phase = PH_SIZE;
                            n_off   = 6'd0;
                        end
                    end
                end
                PH_SIZE: begin
                    n_acc = va;
                    n_off = off + 6'd1;
                    if (off == 6'd3) begin
                        push      = 1'b1;
                        tok.kind  = TK_SIZE;
                        tok.data  = va;
                        tok.chans = r_chans;
                        tok.bits  = r_bits;
                        n_phase   = PH_SAMPLES;
                        n_off     = 6'd0;
                    end
                end
                PH_HEADER: begin
                    n_acc = va;
                    n_off = off + 6'd1;
                    tok.kind = TK_ERR;
                    case (off)
                        6'd3:  if (va != TAG_RIFF) begin
                            push = 1'b1;
                            tok.data = {28'd0, ERR_RIFF};
                        end
                        6'd11: if (va != TAG_WAVE) begin
                            push = 1'b1;
                            tok.data = {28'd0, ERR_WAVE};
                        end
                        6'd15: if (va != TAG_FMT) begin
                            push = 1'b1;
                            tok.data = {28'd0, ERR_FMT};
                        end
                        6'd21: if (va[31:16] != 16'd1) begin
                            push = 1'b1;
                            tok.data = {28'd0, ERR_COMPRESS};
                        end
                        6'd23: begin
                            if (va[31:16] == 16'd0) begin
                                push = 1'b1;
                                tok.data = {28'd0, ERR_CHANNELS};
                            end else begin
                                n_chans = va[31:16];
                            end
                        end
                        6'd27: begin
                            if (va[31]) begin
                                push = 1'b1;
                                tok.data = {28'd0, ERR_RATE};
                            end else begin
                                n_rate = va[30:0];
                            end
                        end
                        6'd35: begin
                            push = 1'b1;
                            if (va[31:16] == 16'd8 || va[31:16] == 16'd16 ||
                                va[31:16] == 16'd24 || va[31:16] == 16'd32) begin
                                n_bits    = va[21:16];
                                tok.kind  = TK_FMT;
                                tok.data  = {1'b0, r_rate};
                                tok.chans = r_chans;
                                tok.bits  = va[21:16];
                            end else begin
                                tok.data = {28'd0, ERR_BITS};
                            end
                        end
                        6'd39: begin
                            n_off = 6'd0;
                            if (va == TAG_JUNK) begin
                                if (JUNK_LEN == 8'd0) begin
                                    n_phase = PH_DATATAG;
                                end else begin
                                    n_phase = PH_JUNK;
                                    n_jcnt  = JUNK_LEN;
                                end
                            end else if (va == TAG_DATA) begin
                                n_phase = PH_SIZE;
                            end else begin
                                push = 1'b1;
                                tok.data = {28'd0, ERR_DATA_TAG};
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (push && tok.kind == TK_ERR) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_off   <= 6'd0;
            r_acc   <= 32'd0;
            r_jcnt  <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_off   <= n_off;
            r_acc   <= n_acc;
            r_jcnt  <= n_jcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chans <= n_chans;
        r_rate  <= n_rate;
        r_bits  <= n_bits;
    end

    assign o_push  = push;
    assign o_token = tok;

endmodule

[sv/wps_queue.sv]
// Small token FIFO between the header front end and the sample back end.
// Uses wps_pkg for the token type and depth.
module wps_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wps_pkg::t_token i_token,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output wps_pkg::t_token o_head
);
    import wps_pkg::*;

    t_token            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp, r_rp;
    logic [Q_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_AW+1)'(Q_DEPTH)) else $error("queue count out of range");

endmodule

[sv/wps_back.sv]
// Sample back end: frame trimming (remainder unit), sample assembly, Q1.30
// scaling and the output register. Uses wps_pkg.
module wps_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  wps_pkg::t_token    i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_kind,
    output logic signed [31:0] o_sample_value,
    output logic [15:0]        o_channel_number,
    output logic [31:0]        o_frame_number,
    output logic               o_last_sample,
    output logic [3:0]         o_error_code,
    output logic [15:0]        o_channel_count,
    output logic [30:0]        o_rate_hz,
    output logic [5:0]         o_sample_bits
);
    import wps_pkg::*;

    // s / (2^p - 1) is the p-bit pattern of |s| repeated; 30 bits plus a round bit.
    function automatic logic [31:0] f_scale(input logic [31:0] raw, input logic [5:0] bits);
        logic signed [32:0] s;
        logic [32:0]        mx;
        logic [31:0]        m;
        logic [63:0]        w;
        logic [30:0]        q;
        logic               big;
        case (bits)
            6'd8:    s = {25'd0, raw[7:0]} - 33'd128;
            6'd16:   s = {{17{raw[15]}}, raw[15:0]};
            6'd24:   s = {{9{raw[23]}}, raw[23:0]};
            default: s = {raw[31], raw};
        endcase
        mx = s[32] ? (33'd0 - s) : s;
        m  = mx[31:0];
        case (bits)
            6'd8: begin
                w   = {m[6:0], m[6:0], m[6:0], m[6:0], m[6:0], m[6:0], m[6:0], m[6:0],
                       m[6:0], 1'b0};
                big = m[7];
            end
            6'd16: begin
                w   = {m[14:0], m[14:0], m[14:0], m[14:0], 4'd0};
                big = m[15];
            end
            6'd24: begin
                w   = {m[22:0], m[22:0], m[22:5]};
                big = m[23];
            end
            default: begin
                w   = {m[30:0], m[30:0], m[30:29]};
                big = m[31];
            end
        endcase
        q = {1'b0, w[63:34]} + 31'(w[33]);
        if (big) begin
            f_scale = 32'hC000_0000;
        end else if (s[32]) begin
            f_scale = 32'd0 - {1'b0, q};
        end else begin
            f_scale = {1'b0, q};
        end
    endfunction

    logic [31:0] r_rem, n_rem;
    logic [31:0] r_acc, n_acc, asm;
    logic [1:0]  r_bis, n_bis;
    logic [15:0] r_chans, n_chans;
    logic [5:0]  r_bits, n_bits;
    logic [15:0] r_chan, n_chan;
    logic [31:0] r_frame, n_frame;
    logic        r_busy, n_busy;
    logic [4:0]  r_dcnt, n_dcnt;
    logic [31:0] r_dvd, n_dvd;
    logic [17:0] r_rmd, n_rmd;
    logic [17:0] r_dvs, n_dvs;
    logic [18:0] dt, dsub;
    logic [2:0]  sbytes;
    logic        pop, emit, slot_free;

    logic        r_ov, n_ov;
    logic [1:0]  r_kind, n_kind;
    logic [31:0] r_val, n_val;
    logic [15:0] r_ochan, n_ochan;
    logic [31:0] r_oframe, n_oframe;
    logic        r_olast, n_olast;
    logic [3:0]  r_oerr, n_oerr;
    logic [15:0] r_occ, n_occ;
    logic [30:0] r_orate, n_orate;
    logic [5:0]  r_obits, n_obits;

    assign sbytes    = r_bits[5:3];
    assign slot_free = !r_ov || !i_out_stall;
    assign asm       = r_acc | ({24'd0, i_head.data[7:0]} << {r_bis, 3'b000});
    assign dt        = {r_rmd, r_dvd[31]};
    assign dsub      = dt - {1'b0, r_dvs};

    always_comb begin
        n_rem = r_rem;  n_acc = r_acc;  n_bis = r_bis;  n_chans = r_chans;
        n_bits = r_bits; n_chan = r_chan; n_frame = r_frame;
        n_busy = r_busy; n_dcnt = r_dcnt; n_dvd = r_dvd; n_rmd = r_rmd; n_dvs = r_dvs;
        n_kind = r_kind; n_val = r_val; n_ochan = r_ochan; n_oframe = r_oframe;
        n_olast = r_olast; n_oerr = r_oerr; n_occ = r_occ; n_orate = r_orate;
        n_obits = r_obits;
        pop  = 1'b0;
        emit = 1'b0;
        if (r_busy) begin
            // one restoring step of size mod frame bytes
            n_rmd  = (dt >= {1'b0, r_dvs}) ? dsub[17:0] : dt[17:0];
            n_dvd  = {r_dvd[30:0], 1'b0};
            n_dcnt = r_dcnt - 5'd1;
            if (r_dcnt == 5'd0) begin
                n_busy = 1'b0;
                n_rem  = r_rem - {14'd0, n_rmd};
            end
        end else if (!i_empty && slot_free) begin
            pop = 1'b1;
            n_val = '0; n_ochan = '0; n_oframe = '0; n_olast = 1'b0;
            n_oerr = '0; n_occ = '0; n_orate = '0; n_obits = '0;
            case (i_head.kind)
                TK_FMT: begin
                    emit    = 1'b1;
                    n_kind  = KIND_FORMAT;
                    n_occ   = i_head.chans;
                    n_orate = i_head.data[30:0];
                    n_obits = i_head.bits;
                end
                TK_ERR: begin
                    emit   = 1'b1;
                    n_kind = KIND_ERROR;
                    n_oerr = i_head.data[3:0];
                end
                TK_SIZE: begin
                    n_rem   = i_head.data;
                    n_dvd   = i_head.data;
                    n_rmd   = '0;
                    n_dvs   = {2'd0, i_head.chans} * {15'd0, i_head.bits[5:3]};
                    n_dcnt  = 5'd31;
                    n_busy  = 1'b1;
                    n_chans = i_head.chans;
                    n_bits  = i_head.bits;
                    n_chan  = '0;
                    n_frame = '0;
                    n_bis   = '0;
                    n_acc   = '0;
                end
                default: begin
                    if (r_rem != 32'd0) begin
                        n_rem = r_rem - 32'd1;
                        if ({1'b0, r_bis} + 3'd1 >= sbytes) begin
                            emit     = 1'b1;
                            n_kind   = KIND_SAMPLE;
                            n_val    = f_scale(asm, r_bits);
                            n_ochan  = r_chan;
                            n_oframe = r_frame;
                            n_olast  = (r_rem == 32'd1);
                            n_acc    = '0;
                            n_bis    = '0;
                            if ({1'b0, r_chan} + 17'd1 >= {1'b0, r_chans}) begin
                                n_chan  = '0;
                                n_frame = r_frame + 32'd1;
                            end else begin
                                n_chan = r_chan + 16'd1;
                            end
                        end else begin
                            n_acc = asm;
                            n_bis = r_bis + 2'd1;
                        end
                    end
                end
            endcase
        end
        if (emit) begin
            n_ov = 1'b1;
        end else if (!i_out_stall) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_bis  <= '0;
            r_busy <= 1'b0;
            r_dcnt <= '0;
            r_ov   <= 1'b0;
            r_chan <= '0;
            r_frame <= '0;
            r_acc  <= '0;
            r_bits <= '0;
        end else begin
            r_rem  <= n_rem;
            r_bis  <= n_bis;
            r_busy <= n_busy;
            r_dcnt <= n_dcnt;
            r_ov   <= n_ov;
            r_chan <= n_chan;
            r_frame <= n_frame;
            r_acc  <= n_acc;
            r_bits <= n_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chans  <= n_chans;
        r_dvd    <= n_dvd;
        r_rmd    <= n_rmd;
        r_dvs    <= n_dvs;
        r_kind   <= n_kind;
        r_val    <= n_val;
        r_ochan  <= n_ochan;
        r_oframe <= n_oframe;
        r_olast  <= n_olast;
        r_oerr   <= n_oerr;
        r_occ    <= n_occ;
        r_orate  <= n_orate;
        r_obits  <= n_obits;
    end

    assign o_pop            = pop;
    assign o_out_valid      = r_ov;
    assign o_kind           = r_kind;
    assign o_sample_value   = r_val;
    assign o_channel_number = r_ochan;
    assign o_frame_number   = r_oframe;
    assign o_last_sample    = r_olast;
    assign o_error_code     = r_oerr;
    assign o_channel_count  = r_occ;
    assign o_rate_hz        = r_orate;
    assign o_sample_bits    = r_obits;

    a_busy_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !pop) else $error("token taken during remainder pass");
    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> slot_free) else $error("result overwrites a held one");
    a_bis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem != 32'd0 && !r_busy) |-> ({1'b0, r_bis} < sbytes))
        else $error("byte position beyond sample width");

endmodule

[sv/wav_pcm_stream_parser.sv]
// Top level of the WAV PCM stream parser: front end, token queue, back end.
// Depends on wps_pkg, wps_front, wps_queue and wps_back.
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_stall    | i_data_byte, i_file_start
//  out     | output    | o_out_valid / i_out_stall  | o_kind ... o_sample_bits
//
// One byte per cycle unless stalled; results registered as the byte leaves the queue.
// The data size token starts a remainder pass in the back end; bytes
// keep entering until the 4-entry queue fills, then o_in_stall rises.
// Synchronous active-low reset; no clearing pass after reset.
// A stalled output holds its result while the queue keeps absorbing bytes.
module wav_pcm_stream_parser #(
    parameter int JUNK_SKIP_BYTES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_file_start,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_kind,
    output logic signed [31:0] o_sample_value,
    output logic [15:0]        o_channel_number,
    output logic [31:0]        o_frame_number,
    output logic               o_last_sample,
    output logic [3:0]         o_error_code,
    output logic [15:0]        o_channel_count,
    output logic [30:0]        o_rate_hz,
    output logic [5:0]         o_sample_bits
);
    import wps_pkg::*;

    logic   q_full, q_empty, push, pop, accept;
    t_token tok, head;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    wps_front #(.JUNK_SKIP_BYTES(JUNK_SKIP_BYTES)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte       (i_data_byte),
        .i_file_start (i_file_start),
        .o_push       (push),
        .o_token      (tok)
    );

    wps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (tok),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    wps_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (q_empty),
        .i_head           (head),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_sample_value   (o_sample_value),
        .o_channel_number (o_channel_number),
        .o_frame_number   (o_frame_number),
        .o_last_sample    (o_last_sample),
        .o_error_code     (o_error_code),
        .o_channel_count  (o_channel_count),
        .o_rate_hz        (o_rate_hz),
        .o_sample_bits    (o_sample_bits)
    );

endmodule
